// ===== src/stwdc_pkg.sv =====
// package for the sliding time window distinct counter
// holds sizes, item and result structs and the queue entry layout
// no dependencies
package stwdc_pkg;

  // queue of (time, key) entries and one occurrence counter per key
  localparam int QUEUE_DEPTH = 4096;
  localparam int KEY_COUNT   = 1024;

  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
  localparam int KEY_AW   = $clog2(KEY_COUNT);
  localparam int FILL_W   = QUEUE_AW + 1;
  // a key can occupy every queue entry at most
  localparam int CNT_W    = FILL_W;

  localparam int TIME_W   = 32;
  localparam int KEY_W    = 10;
  localparam int TOTAL_W  = 11;

  localparam logic [FILL_W-1:0]  FILL_FULL = FILL_W'(QUEUE_DEPTH);
  localparam logic [KEY_AW-1:0]  KEY_LAST  = KEY_AW'(KEY_COUNT - 1);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = TOTAL_W'(KEY_COUNT);

  // register file
  localparam int PADDR_W = 3;
  localparam logic REG_WINDOW = 1'b0;
  localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd86400;

  typedef struct packed {
    logic [TIME_W-1:0] arrival_time;
    logic [KEY_W-1:0]  key;
    logic              has_key;
    logic              group_end;
  } item_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] distinct_count;
    logic               overflow;
  } result_t;

  typedef struct packed {
    logic [TIME_W-1:0] entry_time;
    logic [KEY_AW-1:0] entry_key;
  } entry_t;

endpackage

// ===== src/sliding_time_window_distinct_count.sv =====
// sliding_time_window_distinct_count: one item at a time; an accepted item passes the head
// decision, a head check and decrement for every evicted entry, the push and increment, and
// the done step, which waits while an earlier result stays stalled; the next item can be
// taken in the cycle after the done step.
// rst restores the window register to 86400, clears pointers, totals and flags, then a
// clearing pass over all KEY_COUNT (1024) entries zeroes the key counters; no item is taken until it ends
// depends on stwdc_pkg and stwdc_ram
module sliding_time_window_distinct_count (
  input  logic                            clk,
  input  logic                            rst,
  // item channel
  input  logic                            item_valid,
  output logic                            item_stall,
  input  stwdc_pkg::item_t                item,
  // result channel
  output logic                            result_valid,
  input  logic                            result_stall,
  output stwdc_pkg::result_t              result,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [stwdc_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  // sequencer states
  typedef enum logic [7:0] {
    ST_CLEAR    = 8'b0000_0001,  // zeroing key counters after reset
    ST_IDLE     = 8'b0000_0010,  // waiting for an item
    ST_EV_HEAD  = 8'b0000_0100,  // decide whether the head entry must be checked
    ST_EV_CHECK = 8'b0000_1000,  // head entry data valid, compare against limit
    ST_EV_DEC   = 8'b0001_0000,  // counter data valid, write back decrement
    ST_PUSH     = 8'b0010_0000,  // append entry, read counter of new key
    ST_PUSH_INC = 8'b0100_0000,  // counter data valid, write back increment
    ST_DONE     = 8'b1000_0000   // load result register on group end
  } state_t;

  state_t state, state_next;

  // configuration
  logic [stwdc_pkg::TIME_W-1:0] window_length;
  logic                         reg_idx;
  logic                         cfg_write;

  // working copy of the accepted item and its eviction limit
  stwdc_pkg::item_t             cur;
  logic                         evict_en;
  logic [stwdc_pkg::TIME_W-1:0] limit;

  // queue bookkeeping and totals
  logic [stwdc_pkg::QUEUE_AW-1:0] head;
  logic [stwdc_pkg::QUEUE_AW-1:0] tail;
  logic [stwdc_pkg::FILL_W-1:0]   fill;
  logic [stwdc_pkg::TOTAL_W-1:0]  total;
  logic                           overflow_seen;
  logic [stwdc_pkg::KEY_AW-1:0]   clr_idx;
  logic [stwdc_pkg::KEY_AW-1:0]   ev_key;

  // memory ports
  logic                           q_we;
  stwdc_pkg::entry_t              q_wdata;
  stwdc_pkg::entry_t              q_rdata;
  logic                           c_we;
  logic [stwdc_pkg::KEY_AW-1:0]   c_waddr;
  logic [stwdc_pkg::CNT_W-1:0]    c_wdata;
  logic [stwdc_pkg::KEY_AW-1:0]   c_raddr;
  logic [stwdc_pkg::CNT_W-1:0]    c_rdata;

  logic item_take;
  logic result_take;
  logic result_load;
  logic queue_full;
  logic [stwdc_pkg::KEY_AW-1:0] cur_key;

  // ---------------------------------------------------------------------------
  // configuration port: single register, byte lanes ignored
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_idx   = paddr[stwdc_pkg::PADDR_W-1];
  assign cfg_write = psel & penable & pwrite & pready;

  always_comb begin
    unique case (reg_idx)
      stwdc_pkg::REG_WINDOW: prdata = window_length;
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= stwdc_pkg::WINDOW_RESET;
    end else if (cfg_write && reg_idx == stwdc_pkg::REG_WINDOW) begin
      window_length <= pwdata;
    end
  end

  // ---------------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------------
  // a pending result does not hold off the next item; only the done step waits
  assign item_stall  = (state != ST_IDLE);
  assign item_take   = item_valid & ~item_stall;
  assign result_take = result_valid & ~result_stall;
  assign result_load = (state == ST_DONE) && cur.group_end && (!result_valid || !result_stall);

  assign queue_full = (fill == stwdc_pkg::FILL_FULL);
  // key reduced modulo KEY_COUNT (a power of two)
  assign cur_key    = cur.key[stwdc_pkg::KEY_AW-1:0];

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_idx == stwdc_pkg::KEY_LAST) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (item_take) state_next = ST_EV_HEAD;
      end
      ST_EV_HEAD: begin
        // head entry is read continuously, so its data is ready next cycle
        if (evict_en && fill != '0) state_next = ST_EV_CHECK;
        else                        state_next = ST_PUSH;
      end
      ST_EV_CHECK: begin
        if (q_rdata.entry_time > limit) state_next = ST_PUSH;
        else                            state_next = ST_EV_DEC;
      end
      ST_EV_DEC: begin
        state_next = ST_EV_HEAD;
      end
      ST_PUSH: begin
        if (cur.has_key && !queue_full) state_next = ST_PUSH_INC;
        else                            state_next = ST_DONE;
      end
      ST_PUSH_INC: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!cur.group_end || result_load) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // ---------------------------------------------------------------------------
  // memory controls
  // ---------------------------------------------------------------------------
  // queue: written at the tail on a push, always read at the head
  assign q_we              = (state == ST_PUSH) && cur.has_key && !queue_full;
  assign q_wdata.entry_time = cur.arrival_time;
  assign q_wdata.entry_key  = cur_key;

  // counters: the read of a key and its write-back never share a cycle with
  // another access to the counters, so no forwarding is needed
  always_comb begin
    c_raddr = cur_key;
    if (state == ST_EV_CHECK) c_raddr = q_rdata.entry_key;
  end

  always_comb begin
    c_we    = 1'b0;
    c_waddr = cur_key;
    c_wdata = c_rdata + 1'b1;
    case (state)
      ST_CLEAR: begin
        c_we    = 1'b1;
        c_waddr = clr_idx;
        c_wdata = '0;
      end
      ST_EV_DEC: begin
        c_we    = (c_rdata != '0);
        c_waddr = ev_key;
        c_wdata = c_rdata - 1'b1;
      end
      ST_PUSH_INC: begin
        c_we    = 1'b1;
      end
      default: begin
        c_we    = 1'b0;
      end
    endcase
  end

  stwdc_ram #(
    .WIDTH ($bits(stwdc_pkg::entry_t)),
    .DEPTH (stwdc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (tail),
    .wdata (q_wdata),
    .raddr (head),
    .rdata (q_rdata)
  );

  stwdc_ram #(
    .WIDTH (stwdc_pkg::CNT_W),
    .DEPTH (stwdc_pkg::KEY_COUNT)
  ) u_counts (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  // ---------------------------------------------------------------------------
  // state registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_idx       <= '0;
      head          <= '0;
      tail          <= '0;
      fill          <= '0;
      total         <= '0;
      overflow_seen <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      state <= state_next;

      if (state == ST_CLEAR) clr_idx <= clr_idx + 1'b1;

      // evicted entry: drop its key occurrence, pop the head
      if (state == ST_EV_DEC) begin
        if (c_rdata == stwdc_pkg::CNT_W'(1) && total != '0) total <= total - 1'b1;
        head <= head + 1'b1;
        fill <= fill - 1'b1;
      end

      // push on a full queue drops the key and marks overflow for good
      if (state == ST_PUSH && cur.has_key && queue_full) overflow_seen <= 1'b1;

      if (state == ST_PUSH_INC) begin
        if (c_rdata == '0) total <= total + 1'b1;
        tail <= tail + 1'b1;
        fill <= fill + 1'b1;
      end

      if (result_load)      result_valid <= 1'b1;
      else if (result_take) result_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (item_take) begin
      cur      <= item;
      // nothing is evicted while arrival time is still below the window span
      evict_en <= (item.arrival_time >= window_length);
      limit    <= item.arrival_time - window_length;
    end
    if (state == ST_EV_CHECK) ev_key <= q_rdata.entry_key;
    if (result_load) begin
      result.distinct_count <= total;
      result.overflow       <= overflow_seen;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= stwdc_pkg::FILL_FULL)
    else $error("queue fill count beyond depth");

  a_ptr_fill: assert property (@(posedge clk) disable iff (rst)
    (tail - head) == fill[stwdc_pkg::QUEUE_AW-1:0])
    else $error("queue pointers disagree with fill count");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= stwdc_pkg::TOTAL_MAX)
    else $error("distinct total beyond key count");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    overflow_seen |=> overflow_seen)
    else $error("overflow flag cleared without reset");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_DONE))
    else $error("result raised outside the done step");

endmodule

// ===== src/stwdc_ram.sv =====
// generic single-clock ram, one write port and one registered read port
// used for the entry queue and the per-key counters
// no dependencies
module stwdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench for sliding_time_window_distinct_count: drives items and
// window writes, predicts each group report and compares it with the block's results
// depends on stwdc_pkg and the rtl of the block
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // timeout, far above the slowest legal run (about 1070 items, worst gaps and stalls,
  // every eviction, the counter clearing pass after reset)
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // longest wait for one report, covers a drain of the whole queue
  localparam int unsigned DRAIN_LIMIT = 20_000;
  localparam int unsigned MAX_IDLE    = 13;
  localparam int unsigned PRINT_CAP   = 40;
  localparam logic [stwdc_pkg::PADDR_W-1:0] WINDOW_ADDR =
    stwdc_pkg::PADDR_W'(4 * int'(stwdc_pkg::REG_WINDOW));
  localparam logic [stwdc_pkg::TIME_W-1:0]  TIME_MAX    = 32'hFFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // item channel
  logic               item_valid = 1'b0;
  logic               item_stall;
  stwdc_pkg::item_t   in_item = '0;
  // result channel
  logic               result_valid;
  logic               result_stall = 1'b0;
  stwdc_pkg::result_t out_result;
  // register port
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [stwdc_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  sliding_time_window_distinct_count uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (in_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (out_result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor state: a copy of the entry queue, the per-key occurrence counts,
  // the live key total and the sticky drop flag, plus the window register
  // ---------------------------------------------------------------------------
  logic [stwdc_pkg::TIME_W-1:0] q_time [stwdc_pkg::QUEUE_DEPTH];
  logic [stwdc_pkg::KEY_W-1:0]  q_key  [stwdc_pkg::QUEUE_DEPTH];
  int unsigned                  q_head = 0;
  int unsigned                  q_tail = 0;
  int unsigned                  q_fill = 0;
  int unsigned                  key_occ [stwdc_pkg::KEY_COUNT];
  int unsigned                  live_keys = 0;
  bit                           drop_seen = 1'b0;
  logic [stwdc_pkg::TIME_W-1:0] win_cfg = stwdc_pkg::WINDOW_RESET;
  // evictions caused by the newest item, sizes the quiet time before a write
  int unsigned                  last_evicted = 0;

  // group reports still owed by the block, oldest first
  stwdc_pkg::result_t pending_reports [$];
  int unsigned        err_count = 0;
  int unsigned        cycle_count = 0;
  // idling on or off for the current stretch, shared by both sides
  bit                 idle_on = 1'b1;
  int unsigned        rx_hold = 0;
  stwdc_pkg::result_t want_report;

  function automatic int unsigned idle_cycles();
    return idle_on ? $urandom_range(0, MAX_IDLE) : 0;
  endfunction

  function automatic stwdc_pkg::item_t make_item(input logic [stwdc_pkg::TIME_W-1:0] t,
                                                 input int unsigned k,
                                                 input bit has, input bit last);
    stwdc_pkg::item_t it;
    it.arrival_time = t;
    it.key          = stwdc_pkg::KEY_W'(k);
    it.has_key      = has;
    it.group_end    = last;
    return it;
  endfunction

  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    if (err_count < PRINT_CAP)
      $display("[%0t] mismatch: %s got %0d want %0d", $realtime, what, got, want);
    err_count++;
  endtask

  // window update for one accepted item: drop stale entries from the head, push
  // the key, and queue a report when the item closes a group
  task automatic track_window(input stwdc_pkg::item_t it);
    logic [stwdc_pkg::TIME_W-1:0] cut;
    int unsigned                  k;
    stwdc_pkg::result_t           rep;
    last_evicted = 0;
    // nothing can be stale while the arrival time is below the window span
    if (it.arrival_time >= win_cfg) begin
      cut = it.arrival_time - win_cfg;
      // only the head is tested, so a back-dated entry behind it waits its turn
      while (q_fill != 0 && q_time[q_head] <= cut) begin
        k = int'(q_key[q_head]) % stwdc_pkg::KEY_COUNT;
        if (key_occ[k] != 0) begin
          key_occ[k]--;
          if (key_occ[k] == 0 && live_keys != 0) live_keys--;
        end
        q_head = (q_head + 1) % stwdc_pkg::QUEUE_DEPTH;
        q_fill--;
        last_evicted++;
      end
    end
    if (it.has_key) begin
      // full queue: the key is lost and the drop flag sticks until reset
      if (q_fill >= stwdc_pkg::QUEUE_DEPTH) begin
        drop_seen = 1'b1;
      end else begin
        k = int'(it.key) % stwdc_pkg::KEY_COUNT;
        q_time[q_tail] = it.arrival_time;
        q_key[q_tail]  = stwdc_pkg::KEY_W'(k);
        q_tail = (q_tail + 1) % stwdc_pkg::QUEUE_DEPTH;
        q_fill++;
        if (key_occ[k] == 0) live_keys++;
        key_occ[k]++;
      end
    end
    if (it.group_end) begin
      rep.distinct_count = stwdc_pkg::TOTAL_W'(live_keys);
      rep.overflow       = drop_seen;
      pending_reports.push_back(rep);
    end
  endtask

  // ---------------------------------------------------------------------------
  // item sender: random gap, then hold the item until it is taken; valid stays
  // high into the next item when there is no gap
  // ---------------------------------------------------------------------------
  task automatic send_item(input stwdc_pkg::item_t it);
    int unsigned gap;
    gap = idle_cycles();
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    in_item    <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    track_window(it);
  endtask

  // quiet the item side, wait for every owed report, then let the last item's
  // eviction walk finish so the block is idle
  task automatic settle();
    item_valid <= 1'b0;
    for (int n = 0; n < DRAIN_LIMIT && pending_reports.size() != 0; n++)
      @(posedge clk);
    repeat (16 + 3 * last_evicted) @(posedge clk);
  endtask

  // register access, setup then access phase, then back to idle
  task automatic apb_access(input bit wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= WINDOW_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // write the window span, read it back, and follow it in the predictor
  task automatic write_window(input logic [31:0] span);
    logic [31:0] rd;
    apb_access(1'b1, span, rd);
    win_cfg = span;
    apb_access(1'b0, '0, rd);
    if (rd !== span) flag_mismatch("window readback", rd, span);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stall after each taken result, checked against the
  // oldest owed report field by field
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (result_valid && !result_stall) begin
      if (pending_reports.size() == 0) begin
        flag_mismatch("result with no report owed", out_result, 0);
      end else begin
        want_report = pending_reports.pop_front();
        if (out_result.distinct_count !== want_report.distinct_count)
          flag_mismatch("distinct_count", out_result.distinct_count,
                        want_report.distinct_count);
        if (out_result.overflow !== want_report.overflow)
          flag_mismatch("overflow", out_result.overflow, want_report.overflow);
      end
      rx_hold = idle_cycles();
    end else if (rx_hold != 0) begin
      rx_hold--;
    end
    result_stall <= (rx_hold != 0);
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // the window register comes out of reset at one day of seconds
  task automatic test_window_reset();
    logic [31:0] rd;
    apb_access(1'b0, '0, rd);
    if (rd !== stwdc_pkg::WINDOW_RESET)
      flag_mismatch("window after reset", rd, stwdc_pkg::WINDOW_RESET);
  endtask

  // hand-picked items: early times, keys at both ends, all flag mixes,
  // back-dated time, zero window and widest window
  task automatic test_directed();
    // reset window: early arrivals evict nothing
    send_item(make_item(32'd0, 0, 1'b1, 1'b1));
    send_item(make_item(32'd0, stwdc_pkg::KEY_COUNT - 1, 1'b1, 1'b1));
    send_item(make_item(32'd5, 0, 1'b1, 1'b0));
    send_item(make_item(32'd5, 0, 1'b0, 1'b1));
    // first evictions: time 0 entries go, the key 0 repeat keeps it alive
    send_item(make_item(32'd86400, 7, 1'b1, 1'b1));
    send_item(make_item(32'd86405, 0, 1'b0, 1'b1));
    // back-dated entry lands behind newer ones and survives the next sweep
    send_item(make_item(32'd100, 3, 1'b1, 1'b1));
    send_item(make_item(32'd86500, 9, 1'b1, 1'b1));
    send_item(make_item(32'd86500, stwdc_pkg::KEY_COUNT - 1, 1'b0, 1'b0));
    settle();

    // zero window: every entry goes on the next item
    write_window(32'd0);
    send_item(make_item(32'd90000, 5, 1'b1, 1'b1));
    send_item(make_item(32'd90000, 5, 1'b1, 1'b1));
    send_item(make_item(32'd90000, 6, 1'b1, 1'b1));
    settle();

    // widest window: nothing stale until the clock hits its top
    write_window(TIME_MAX);
    send_item(make_item(TIME_MAX - 1, 1, 1'b1, 1'b1));
    send_item(make_item(TIME_MAX, 2, 1'b1, 1'b1));
    settle();

    // flush everything so the random phases start from an empty queue
    write_window(32'd0);
    send_item(make_item(TIME_MAX, 0, 1'b0, 1'b1));
  endtask

  // six phases of random traffic, each with its own window span and time base;
  // steps are scaled to the window up to a cap, so in most phases entries come and go
  task automatic test_random();
    logic [stwdc_pkg::TIME_W-1:0] phase_base [6];
    logic [stwdc_pkg::TIME_W-1:0] span, t, t_item, step, back;
    int unsigned                  step_max, key_base, k;
    bit                           has, last;
    phase_base = '{32'h0000_0000, 32'h0012_3456, 32'h2AAA_0000,
                   32'h5555_0000, 32'h7FFF_0000, 32'hFF00_0000};
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: span = 32'd1;
        1: span = $urandom_range(2, 40);
        2: span = $urandom_range(100, 5000);
        3: span = stwdc_pkg::WINDOW_RESET;
        4: span = $urandom_range(32'h0001_0000, 32'h0004_0000);
        default: span = TIME_MAX;
      endcase
      settle();
      write_window(span);
      step_max = (span > 32'd98304) ? 16384 : int'(span / 6) + 2;
      t        = phase_base[p];
      key_base = $urandom_range(0, stwdc_pkg::KEY_COUNT - 1);
      for (int i = 0; i < 175; i++) begin
        // stretches with and without idling on both sides
        if ((i % 30) == 0) idle_on = ($urandom_range(0, 3) != 0);
        step = $urandom_range(0, step_max);
        t = (t > TIME_MAX - step) ? TIME_MAX : t + step;
        t_item = t;
        // now and then a back-dated item
        if ($urandom_range(0, 29) == 0) begin
          back   = $urandom_range(1, step_max * 4);
          t_item = (t > back) ? t - back : 32'd0;
        end
        // mostly a small key pool so counts climb above one
        if ($urandom_range(0, 4) != 0)
          k = (key_base + $urandom_range(0, 15)) % stwdc_pkg::KEY_COUNT;
        else
          k = $urandom_range(0, stwdc_pkg::KEY_COUNT - 1);
        has  = ($urandom_range(0, 6) != 0);
        last = ($urandom_range(0, 4) < 2);
        send_item(make_item(t_item, k, has, last));
      end
    end
    idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // run control
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  initial begin : main_seq
    stwdc_pkg::result_t left_over;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_window_reset();
    test_directed();
    test_random();
    settle();
    // anything still owed was never delivered
    while (pending_reports.size() != 0) begin
      left_over = pending_reports.pop_front();
      flag_mismatch("report never delivered", 0, left_over.distinct_count);
    end
    if (err_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/stwdc_pkg.sv
src/stwdc_ram.sv
src/sliding_time_window_distinct_count.sv
dv/testbench.sv
